// ===== hw/rtl/mac_address_table_with_filter_walk_macros.svh =====
// assertion helpers, evaluated on clk with rst masking
`ifndef MAC_ADDRESS_TABLE_WITH_FILTER_WALK_MACROS_SVH
`define MAC_ADDRESS_TABLE_WITH_FILTER_WALK_MACROS_SVH

// same-cycle implication
`define MFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mft check failed");

// next-cycle implication
`define MFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mft check failed");

`endif

// ===== hw/rtl/mft_pkg.sv =====
package mft_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int OWNER_BITS_DEF  = 4;
  localparam int MAC_W           = 48;
  localparam int FUNC_W          = 3;
  localparam int OUT_W           = 56;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD       = 3'd0,
    FN_DELETE    = 3'd1,
    FN_FLUSH     = 3'd2,
    FN_GET_FIRST = 3'd3,
    FN_GET_NEXT  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CRIT_ALL        = 2'd0,
    CRIT_OWNER      = 2'd1,
    CRIT_TYPE       = 2'd2,
    CRIT_OWNER_TYPE = 2'd3
  } crit_t;

  typedef enum logic [1:0] {
    AT_BCAST = 2'd0,
    AT_MCAST = 2'd1,
    AT_UCAST = 2'd2,
    AT_ANY   = 2'd3
  } addr_type_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_FIN
  } ctrl_state_t;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic step;
    logic keep;
    logic append;
  } cell_ctl_t;

  function automatic logic type_ok(input logic [MAC_W-1:0] mac, input logic [1:0] at);
    logic bcast;
    logic group;
    logic res;
    bcast = &mac;
    group = mac[40];
    case (at)
      AT_BCAST: res = bcast;
      AT_MCAST: res = group && !bcast;
      AT_UCAST: res = !group;
      default:  res = 1'b1;
    endcase
    return res;
  endfunction

  function automatic logic crit_match(input logic own_eq, input logic type_hit,
                                      input logic [1:0] crit);
    logic res;
    case (crit)
      CRIT_ALL:   res = 1'b1;
      CRIT_OWNER: res = own_eq;
      CRIT_TYPE:  res = type_hit;
      default:    res = own_eq && type_hit;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/mft_cell.sv =====
module mft_cell import mft_pkg::*; #(
  parameter int IDX        = 0,
  parameter int OWNER_BITS = OWNER_BITS_DEF,
  parameter int CNT_W      = 6
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [CNT_W-1:0]      len,
  input  logic [CNT_W-1:0]      wr_pos,
  input  logic [MAC_W-1:0]      nb_mac,
  input  logic [OWNER_BITS-1:0] nb_owner,
  input  logic [MAC_W-1:0]      head_mac,
  input  logic [OWNER_BITS-1:0] head_owner,
  input  logic [MAC_W-1:0]      app_mac,
  input  logic [OWNER_BITS-1:0] app_owner,
  output logic [MAC_W-1:0]      mac,
  output logic [OWNER_BITS-1:0] owner
);

  localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);

  // unprocessed entries move toward the head, kept head entry lands at the tail
  always_ff @(posedge clk) begin
    if (ctl.append && wr_pos == MY_IDX) begin
      mac   <= app_mac;
      owner <= app_owner;
    end else if (ctl.step) begin
      if (NEXT_IDX < len) begin
        mac   <= nb_mac;
        owner <= nb_owner;
      end else if (NEXT_IDX == len && ctl.keep) begin
        mac   <= head_mac;
        owner <= head_owner;
      end
    end
  end

endmodule

// ===== hw/rtl/mft_ctrl.sv =====
`include "mac_address_table_with_filter_walk_macros.svh"

module mft_ctrl import mft_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int OWNER_BITS  = OWNER_BITS_DEF,
  parameter int CNT_W       = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [MAC_W-1:0]      in_mac,
  input  logic [OWNER_BITS-1:0] in_owner,
  input  logic [1:0]            in_crit,
  input  logic [1:0]            in_type,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [1:0]            out_status,
  output logic [MAC_W-1:0]      out_mac,
  input  logic [MAC_W-1:0]      head_mac,
  input  logic [OWNER_BITS-1:0] head_owner,
  output cell_ctl_t             ctl,
  output logic [CNT_W-1:0]      len_out,
  output logic [CNT_W-1:0]      wr_pos,
  output logic [MAC_W-1:0]      app_mac,
  output logic [OWNER_BITS-1:0] app_owner
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  ctrl_state_t state, state_next;

  logic [FUNC_W-1:0]     func_q;
  logic [MAC_W-1:0]      req_mac;
  logic [OWNER_BITS-1:0] req_owner;
  logic [1:0]            req_crit, req_type;
  logic [CNT_W-1:0]      k, k_next;
  logic [CNT_W-1:0]      len, len_next;
  logic [CNT_W-1:0]      w, w_next;
  logic                  hit, hit_next;
  logic [CNT_W-1:0]      hit_idx, hit_idx_next;
  logic [MAC_W-1:0]      found, found_next;

  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      cursor_pos, cursor_pos_next;
  logic                  cursor_at_end, cursor_at_end_next;
  logic [1:0]            saved_crit, saved_crit_next;
  logic [1:0]            saved_type, saved_type_next;
  logic [OWNER_BITS-1:0] saved_owner, saved_owner_next;

  logic                  out_valid_next;
  logic [1:0]            out_status_next;
  logic [MAC_W-1:0]      out_mac_next;

  logic                  accept, step, fin_go, drop;
  logic                  pair_eq, m_req, m_sav;
  logic                  set_c;
  logic [CNT_W-1:0]      pos_c, cnt_c;

  assign accept   = in_valid && in_ready;
  assign step     = (state == S_PASS) && (k != count);
  assign fin_go   = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);
  assign pair_eq  = (head_mac == req_mac) && (head_owner == req_owner);
  assign m_req    = crit_match(head_owner == req_owner, type_ok(head_mac, req_type), req_crit);
  assign m_sav    = crit_match(head_owner == saved_owner, type_ok(head_mac, saved_type),
                               saved_crit);
  assign len_out   = len;
  assign wr_pos    = count;
  assign app_mac   = req_mac;
  assign app_owner = req_owner;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      cursor_pos    <= '0;
      cursor_at_end <= 1'b1;
      saved_crit    <= CRIT_ALL;
      saved_type    <= AT_BCAST;
      saved_owner   <= '0;
      m_axis_tvalid <= 1'b0;
      hit           <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      cursor_pos    <= cursor_pos_next;
      cursor_at_end <= cursor_at_end_next;
      saved_crit    <= saved_crit_next;
      saved_type    <= saved_type_next;
      saved_owner   <= saved_owner_next;
      m_axis_tvalid <= out_valid_next;
      hit           <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= in_func;
      req_mac   <= in_mac;
      req_owner <= in_owner;
      req_crit  <= in_crit;
      req_type  <= in_type;
    end
    k          <= k_next;
    len        <= len_next;
    w          <= w_next;
    hit_idx    <= hit_idx_next;
    found      <= found_next;
    out_status <= out_status_next;
    out_mac    <= out_mac_next;
  end

  always_comb begin
    state_next         = state;
    k_next             = k;
    len_next           = len;
    w_next             = w;
    hit_next           = hit;
    hit_idx_next       = hit_idx;
    found_next         = found;
    count_next         = count;
    cursor_pos_next    = cursor_pos;
    cursor_at_end_next = cursor_at_end;
    saved_crit_next    = saved_crit;
    saved_type_next    = saved_type;
    saved_owner_next   = saved_owner;
    out_valid_next     = m_axis_tvalid && !m_axis_tready;
    out_status_next    = out_status;
    out_mac_next       = out_mac;
    in_ready           = 1'b0;
    drop               = 1'b0;
    set_c              = 1'b0;
    pos_c              = '0;
    cnt_c              = count;
    ctl                = '0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          k_next     = '0;
          len_next   = count;
          w_next     = '0;
          hit_next   = 1'b0;
          state_next = S_PASS;
        end
      end

      S_PASS: begin
        if (!step) begin
          state_next = S_FIN;
        end else begin
          case (func_q)
            FN_ADD: begin
              if (pair_eq && !hit) begin
                hit_next     = 1'b1;
                hit_idx_next = k;
              end
            end
            FN_DELETE: begin
              drop = pair_eq && !hit;
              if (pair_eq && !hit) begin
                hit_next     = 1'b1;
                hit_idx_next = k;
              end
            end
            FN_FLUSH: begin
              drop = m_req;
              // survivors ahead of the cursor entry give its new place
              if (!cursor_at_end && k == cursor_pos) hit_idx_next = w;
            end
            FN_GET_FIRST: begin
              if (m_req && !hit) begin
                hit_next     = 1'b1;
                hit_idx_next = k;
                found_next   = head_mac;
              end
            end
            FN_GET_NEXT: begin
              if (!cursor_at_end && k >= cursor_pos && m_sav && !hit) begin
                hit_next     = 1'b1;
                hit_idx_next = k;
                found_next   = head_mac;
              end
            end
            default: ;
          endcase
          ctl.step = 1'b1;
          ctl.keep = !drop;
          k_next   = k + CNT_W'(1);
          w_next   = w + CNT_W'(!drop);
          len_next = len - CNT_W'(drop);
        end
      end

      S_FIN: begin
        if (fin_go) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_mac_next    = '0;
          state_next      = S_IDLE;
          case (func_q)
            FN_ADD: begin
              if (hit) begin
                out_status_next = ST_EXISTS;
              end else if (count >= DEPTH_C) begin
                out_status_next = ST_FULL;
              end else begin
                ctl.append = 1'b1;
                count_next = count + CNT_W'(1);
                if (cursor_at_end) begin
                  cursor_pos_next    = count;
                  cursor_at_end_next = 1'b0;
                end
              end
            end
            FN_DELETE: begin
              if (!hit) begin
                out_status_next = ST_NOT_FOUND;
              end else begin
                count_next = len;
                cnt_c      = len;
                set_c      = !cursor_at_end;
                pos_c      = (cursor_pos > hit_idx) ? cursor_pos - CNT_W'(1) : cursor_pos;
              end
            end
            FN_FLUSH: begin
              count_next = len;
              cnt_c      = len;
              set_c      = !cursor_at_end;
              pos_c      = hit_idx;
            end
            FN_GET_FIRST: begin
              if (hit) begin
                out_mac_next     = found;
                set_c            = 1'b1;
                pos_c            = hit_idx + CNT_W'(1);
                saved_crit_next  = req_crit;
                saved_type_next  = req_type;
                saved_owner_next = req_owner;
              end else begin
                out_status_next = ST_NOT_FOUND;
              end
            end
            FN_GET_NEXT: begin
              set_c = 1'b1;
              if (hit) begin
                out_mac_next = found;
                pos_c        = hit_idx + CNT_W'(1);
              end else begin
                out_status_next = ST_NOT_FOUND;
                pos_c           = count;
              end
            end
            default: ;
          endcase
          if (set_c) begin
            if (pos_c >= cnt_c) begin
              cursor_pos_next    = '0;
              cursor_at_end_next = 1'b1;
            end else begin
              cursor_pos_next    = pos_c;
              cursor_at_end_next = 1'b0;
            end
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  `MFT_ASSERT_NOW(a_cursor_in_table, !cursor_at_end, cursor_pos < count)
  `MFT_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_C)
  `MFT_ASSERT_NOW(a_pass_len, step, len == count - k + w)
  `MFT_ASSERT_NOW(a_err_no_mac, m_axis_tvalid && out_status != ST_OK, out_mac == '0)
  `MFT_ASSERT_NEXT(a_fin_delivers, fin_go, m_axis_tvalid && state == S_IDLE)

endmodule

// ===== hw/rtl/mac_address_table_with_filter_walk.sv =====
// a new request is taken only after the previous result is registered for output; each pass
//   rotates the cell row one entry per cycle past the single compare unit at its head
// reset: clears entry count, cursor (at end), saved walk criterion and the output valid;
//   table cells are not cleared and need no clearing pass
module mac_address_table_with_filter_walk import mft_pkg::*; #(
  parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter  int OWNER_BITS  = OWNER_BITS_DEF,
  localparam int IN_W        = ((MAC_W + OWNER_BITS + 4 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // mac_in, owner_id, criterion, addr_type, zero fill
  input  logic [IN_W-1:0]   s_axis_tdata,
  // func
  input  logic [FUNC_W-1:0] s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status, mac_out, zero fill
  output logic [OUT_W-1:0]  m_axis_tdata
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [MAC_W-1:0]      in_mac;
  logic [OWNER_BITS-1:0] in_owner;
  logic [1:0]            in_crit, in_type;
  logic [1:0]            out_status;
  logic [MAC_W-1:0]      out_mac;

  logic [MAC_W-1:0]      cell_mac   [TABLE_DEPTH];
  logic [OWNER_BITS-1:0] cell_owner [TABLE_DEPTH];

  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      len, wr_pos;
  logic [MAC_W-1:0]      app_mac;
  logic [OWNER_BITS-1:0] app_owner;

  assign in_mac   = s_axis_tdata[MAC_W-1:0];
  assign in_owner = s_axis_tdata[MAC_W +: OWNER_BITS];
  assign in_crit  = s_axis_tdata[MAC_W + OWNER_BITS +: 2];
  assign in_type  = s_axis_tdata[MAC_W + OWNER_BITS + 2 +: 2];

  assign m_axis_tdata = {{(OUT_W - MAC_W - 2){1'b0}}, out_mac, out_status};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      mft_cell #(.IDX(i), .OWNER_BITS(OWNER_BITS), .CNT_W(CNT_W)) u_cell (
        .clk(clk), .ctl(ctl), .len(len), .wr_pos(wr_pos),
        .nb_mac(cell_mac[0]), .nb_owner(cell_owner[0]),
        .head_mac(cell_mac[0]), .head_owner(cell_owner[0]),
        .app_mac(app_mac), .app_owner(app_owner),
        .mac(cell_mac[i]), .owner(cell_owner[i])
      );
    end else begin : g_body
      mft_cell #(.IDX(i), .OWNER_BITS(OWNER_BITS), .CNT_W(CNT_W)) u_cell (
        .clk(clk), .ctl(ctl), .len(len), .wr_pos(wr_pos),
        .nb_mac(cell_mac[i+1]), .nb_owner(cell_owner[i+1]),
        .head_mac(cell_mac[0]), .head_owner(cell_owner[0]),
        .app_mac(app_mac), .app_owner(app_owner),
        .mac(cell_mac[i]), .owner(cell_owner[i])
      );
    end
  end

  mft_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .OWNER_BITS(OWNER_BITS), .CNT_W(CNT_W)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_func(s_axis_tuser),
    .in_mac(in_mac),
    .in_owner(in_owner),
    .in_crit(in_crit),
    .in_type(in_type),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .out_status(out_status),
    .out_mac(out_mac),
    .head_mac(cell_mac[0]),
    .head_owner(cell_owner[0]),
    .ctl(ctl),
    .len_out(len),
    .wr_pos(wr_pos),
    .app_mac(app_mac),
    .app_owner(app_owner)
  );

endmodule
